### rtl/csg_pkg.sv
`timescale 1ns / 1ps
package csg_pkg;

  localparam int MAX_N_DEF     = 32;
  localparam int ELEM_BITS_DEF = 16;
  localparam int SUM_W         = 38;
  localparam int IDX_W         = 5;
  localparam int CFG_W         = 6;
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(32);

  // Control half of the beat handed from cell to cell
  typedef struct packed {
    logic valid;
    logic first;
  } link_ctl_t;

endpackage

### rtl/csg_elem_if.sv
`timescale 1ns / 1ps
interface csg_elem_if #(
  parameter int ELEM_BITS = 16
);
  logic                        valid;
  logic                        ready;
  logic signed [ELEM_BITS-1:0] elem_real;
  logic signed [ELEM_BITS-1:0] elem_imag;

  modport source (output valid, elem_real, elem_imag, input ready);
  modport sink   (input valid, elem_real, elem_imag, output ready);
endinterface

### rtl/csg_sum_if.sv
`timescale 1ns / 1ps
interface csg_sum_if;
  logic              valid;
  logic              ready;
  logic signed [37:0] sum_real;
  logic signed [37:0] sum_imag;
  logic [4:0]        out_row;
  logic [4:0]        out_col;
  logic              run_last;

  modport source (output valid, sum_real, sum_imag, out_row, out_col, run_last,
                  input ready);
  modport sink   (input valid, sum_real, sum_imag, out_row, out_col, run_last,
                  output ready);
endinterface

### rtl/csg_cell.sv
`timescale 1ns / 1ps
module csg_cell #(
  parameter int MAX_N     = 32,
  parameter int ELEM_BITS = 16,
  parameter int CELL_IDX  = 0,
  parameter int CW        = 5,
  parameter int AW        = 38
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  csg_pkg::link_ctl_t          ctl_in,
  input  logic [CW-1:0]               row_in,
  input  logic [CW-1:0]               col_in,
  input  logic signed [ELEM_BITS-1:0] re_in,
  input  logic signed [ELEM_BITS-1:0] im_in,
  output csg_pkg::link_ctl_t          ctl_out,
  output logic [CW-1:0]               row_out,
  output logic [CW-1:0]               col_out,
  output logic signed [ELEM_BITS-1:0] re_out,
  output logic signed [ELEM_BITS-1:0] im_out,
  output logic signed [AW-1:0]        acc_re,
  output logic signed [AW-1:0]        acc_im
);
  import csg_pkg::*;

  localparam int PW = 2 * ELEM_BITS;

  // Row CELL_IDX of the matrix
  logic signed [ELEM_BITS-1:0] row_re [MAX_N];
  logic signed [ELEM_BITS-1:0] row_im [MAX_N];

  link_ctl_t                   ctl_r;
  logic [CW-1:0]               row_r, col_r;
  logic signed [ELEM_BITS-1:0] re_r, im_r;
  logic signed [ELEM_BITS-1:0] rd_re_r, rd_im_r;
  logic                        self_r, act_r;

  logic                        pvalid_r, pfirst_r;
  logic signed [PW-1:0]        p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [AW-1:0]        acc_re_r, acc_im_r;

  logic signed [ELEM_BITS-1:0] ar, ai;
  logic                        self_hit, act_hit;

  assign self_hit = (row_in == CW'(CELL_IDX));
  assign act_hit  = (row_in >= CW'(CELL_IDX));

  // Store own row, read the element at this column, forward the beat
  always_ff @(posedge clk) begin
    if (ctl_in.valid && self_hit) begin
      row_re[col_in] <= re_in;
      row_im[col_in] <= im_in;
    end
    rd_re_r <= row_re[col_in];
    rd_im_r <= row_im[col_in];
    row_r   <= row_in;
    col_r   <= col_in;
    re_r    <= re_in;
    im_r    <= im_in;
    self_r  <= self_hit;
    act_r   <= act_hit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  assign ctl_out = ctl_r;
  assign row_out = row_r;
  assign col_out = col_r;
  assign re_out  = re_r;
  assign im_out  = im_r;

  // Own element, or the passing one when this cell holds the row in flight
  assign ar = self_r ? re_r : rd_re_r;
  assign ai = self_r ? im_r : rd_im_r;

  // Form the four partial products
  always_ff @(posedge clk) begin
    p_rr_r   <= ar * re_r;
    p_ii_r   <= ai * im_r;
    p_ri_r   <= ar * im_r;
    p_ir_r   <= re_r * ai;
    pfirst_r <= ctl_r.first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvalid_r <= 1'b0;
    end else begin
      pvalid_r <= ctl_r.valid && act_r;
    end
  end

  // Accumulate, restarting on column zero
  always_ff @(posedge clk) begin
    if (pvalid_r) begin
      if (pfirst_r) begin
        acc_re_r <= AW'(p_rr_r) - AW'(p_ii_r);
        acc_im_r <= AW'(p_ri_r) + AW'(p_ir_r);
      end else begin
        acc_re_r <= acc_re_r + AW'(p_rr_r) - AW'(p_ii_r);
        acc_im_r <= acc_im_r + AW'(p_ri_r) + AW'(p_ir_r);
      end
    end
  end

  assign acc_re = acc_re_r;
  assign acc_im = acc_im_r;

endmodule

### rtl/complex_symmetric_gram_upper_top.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle within a row; a completing beat then holds
// input while the row settles in the cell chain (S_WAIT) and until its j+1
// result beats have drained (S_DRAIN).
// Reset (rst_n, synchronous): size 32, load position (0,0); store undefined.
module complex_symmetric_gram_upper_top #(
  parameter int MAX_N     = csg_pkg::MAX_N_DEF,
  parameter int ELEM_BITS = csg_pkg::ELEM_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [csg_pkg::CFG_W-1:0] cfg_data,
  csg_elem_if.sink                  in_ch,
  csg_sum_if.source                 out_ch
);
  import csg_pkg::*;

  localparam int CW     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int NW     = ($clog2(MAX_N + 1) > CFG_W) ? $clog2(MAX_N + 1) : CFG_W;
  localparam int AW     = (2 * ELEM_BITS + 7 > SUM_W) ? 2 * ELEM_BITS + 7 : SUM_W;
  localparam int WAIT_N = MAX_N + 4;
  localparam int WW     = $clog2(WAIT_N + 1);

  typedef enum logic [1:0] {S_LOAD, S_WAIT, S_DRAIN} state_t;

  state_t            state_r;
  logic [CFG_W-1:0]  size_r;
  logic [CW-1:0]     lrow_r, lcol_r, jrow_r;
  logic [WW-1:0]     wait_r;
  logic [CW:0]       cnt_r;

  logic [NW-1:0]     n_eff, size_x;
  logic              beat, row_done;

  link_ctl_t                   ctl   [MAX_N+1];
  logic [CW-1:0]               lrow  [MAX_N+1];
  logic [CW-1:0]               lcol  [MAX_N+1];
  logic signed [ELEM_BITS-1:0] lre   [MAX_N+1];
  logic signed [ELEM_BITS-1:0] lim   [MAX_N+1];
  logic signed [AW-1:0]        acc_re [MAX_N];
  logic signed [AW-1:0]        acc_im [MAX_N];

  logic              ov_r, olast_r;
  logic signed [SUM_W-1:0] ore_r, oim_r;
  logic [IDX_W-1:0]  orow_r, ocol_r;

  // Clamp the size to 1..MAX_N
  assign size_x = NW'(size_r);
  always_comb begin
    if (size_x == '0) begin
      n_eff = NW'(1);
    end else if (size_x > NW'(MAX_N)) begin
      n_eff = NW'(MAX_N);
    end else begin
      n_eff = size_x;
    end
  end

  assign in_ch.ready = (state_r == S_LOAD);
  assign beat        = in_ch.valid && in_ch.ready;
  assign row_done    = (NW'(lcol_r) == n_eff - NW'(1));

  // Head of the chain
  always_ff @(posedge clk) begin
    lrow[0] <= lrow_r;
    lcol[0] <= lcol_r;
    lre[0]  <= in_ch.elem_real;
    lim[0]  <= in_ch.elem_imag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl[0] <= '0;
    end else begin
      ctl[0].valid <= beat;
      ctl[0].first <= (lcol_r == '0);
    end
  end

  for (genvar g = 0; g < MAX_N; g++) begin : g_cell
    csg_cell #(
      .MAX_N(MAX_N), .ELEM_BITS(ELEM_BITS), .CELL_IDX(g), .CW(CW), .AW(AW)
    ) u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl_in(ctl[g]), .row_in(lrow[g]), .col_in(lcol[g]),
      .re_in(lre[g]), .im_in(lim[g]),
      .ctl_out(ctl[g+1]), .row_out(lrow[g+1]), .col_out(lcol[g+1]),
      .re_out(lre[g+1]), .im_out(lim[g+1]),
      .acc_re(acc_re[g]), .acc_im(acc_im[g])
    );
  end

  // Sequence loading, settling and draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      size_r  <= SIZE_RESET;
      lrow_r  <= '0;
      lcol_r  <= '0;
      jrow_r  <= '0;
      wait_r  <= '0;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (cfg_we) begin
            size_r <= cfg_data;
            lrow_r <= '0;
            lcol_r <= '0;
          end else if (beat) begin
            if (row_done) begin
              lcol_r <= '0;
              jrow_r <= lrow_r;
              lrow_r <= (NW'(lrow_r) == n_eff - NW'(1)) ? '0 : lrow_r + CW'(1);
              wait_r <= '0;
              state_r <= S_WAIT;
            end else begin
              lcol_r <= lcol_r + CW'(1);
            end
          end
        end
        S_WAIT: begin
          wait_r <= wait_r + WW'(1);
          if (wait_r == WW'(WAIT_N)) begin
            cnt_r   <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!ov_r || out_ch.ready) begin
            if (cnt_r <= {1'b0, jrow_r}) begin
              ov_r    <= 1'b1;
              ore_r   <= acc_re[cnt_r[CW-1:0]][SUM_W-1:0];
              oim_r   <= acc_im[cnt_r[CW-1:0]][SUM_W-1:0];
              orow_r  <= IDX_W'(cnt_r);
              ocol_r  <= IDX_W'(jrow_r);
              olast_r <= (cnt_r == {1'b0, jrow_r});
              cnt_r   <= cnt_r + (CW+1)'(1);
            end else begin
              ov_r    <= 1'b0;
              state_r <= S_LOAD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_ch.valid    = ov_r;
  assign out_ch.sum_real = ore_r;
  assign out_ch.sum_imag = oim_r;
  assign out_ch.out_row  = orow_r;
  assign out_ch.out_col  = ocol_r;
  assign out_ch.run_last = olast_r;

endmodule

### tb/gram_checker.sv
`timescale 1ns / 1ps
module gram_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [csg_pkg::CFG_W-1:0] cfg_data,
  csg_elem_if                       in_ch,
  csg_sum_if                        out_ch,
  output int                        errors,
  output int                        pending,
  output int                        checked
);
  import csg_pkg::*;

  typedef struct {
    logic signed [SUM_W-1:0] re;
    logic signed [SUM_W-1:0] im;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic                    last;
  } gram_entry_t;

  logic signed [15:0] mat_re [MAX_N_DEF][MAX_N_DEF];
  logic signed [15:0] mat_im [MAX_N_DEF][MAX_N_DEF];
  logic [CFG_W-1:0]   size_reg;
  int                 ld_row;
  int                 ld_col;
  gram_entry_t        gram_q[$];

  // Clamp the size register to 1..MAX_N
  function automatic int dim_in_use(logic [CFG_W-1:0] s);
    if (s == 0) return 1;
    if (s > MAX_N_DEF) return MAX_N_DEF;
    return int'(s);
  endfunction

  task automatic report(string what, logic signed [SUM_W-1:0] got,
                        logic signed [SUM_W-1:0] want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Queue the upper-triangle column j once row j is complete
  task automatic push_column(int j, int n);
    gram_entry_t e;
    longint      acc_re;
    longint      acc_im;
    longint      ar, ai, br, bi;
    for (int i = 0; i <= j; i++) begin
      acc_re = 0;
      acc_im = 0;
      for (int k = 0; k < n; k++) begin
        ar = mat_re[i][k];
        ai = mat_im[i][k];
        br = mat_re[j][k];
        bi = mat_im[j][k];
        acc_re += ar * br - ai * bi;
        acc_im += ar * bi + br * ai;
      end
      e.re   = acc_re[SUM_W-1:0];
      e.im   = acc_im[SUM_W-1:0];
      e.row  = i[IDX_W-1:0];
      e.col  = j[IDX_W-1:0];
      e.last = (i == j);
      gram_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    gram_entry_t e;
    int          n;
    if (!rst_n) begin
      size_reg = SIZE_RESET;
      ld_row   = 0;
      ld_col   = 0;
      errors   = 0;
      checked  = 0;
      gram_q.delete();
    end else begin
      // Track register writes: restart loading
      if (cfg_we) begin
        size_reg = cfg_data;
        ld_row   = 0;
        ld_col   = 0;
      end
      // Store an accepted element beat
      if (in_ch.valid && in_ch.ready) begin
        n = dim_in_use(size_reg);
        if (ld_row >= n) ld_row = 0;
        if (ld_col >= n) ld_col = 0;
        mat_re[ld_row][ld_col] = in_ch.elem_real;
        mat_im[ld_row][ld_col] = in_ch.elem_imag;
        ld_col++;
        if (ld_col >= n) begin
          ld_col = 0;
          push_column(ld_row, n);
          ld_row = (ld_row + 1 >= n) ? 0 : ld_row + 1;
        end
      end
      // Compare an accepted result beat
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (gram_q.size() == 0) begin
          report("unexpected result row", out_ch.out_row, 0);
        end else begin
          e = gram_q.pop_front();
          if (out_ch.sum_real !== e.re) report("sum_real", out_ch.sum_real, e.re);
          if (out_ch.sum_imag !== e.im) report("sum_imag", out_ch.sum_imag, e.im);
          if (out_ch.out_row !== e.row) report("out_row", out_ch.out_row, e.row);
          if (out_ch.out_col !== e.col) report("out_col", out_ch.out_col, e.col);
          if (out_ch.run_last !== e.last) report("run_last", out_ch.run_last, e.last);
        end
      end
    end
    pending = gram_q.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import csg_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  int               errors;
  int               pending;
  int               checked;
  int               beats_sent;
  int               settings_used;
  int               burst_left;
  bit               hold_req;
  bit               hold_done;

  csg_elem_if #(.ELEM_BITS(ELEM_BITS_DEF)) in_ch ();
  csg_sum_if out_ch ();

  complex_symmetric_gram_upper_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  gram_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bound the run
  initial begin
    #40ms;
    $display("timeout with %0d results outstanding", pending);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: stretches of steady, random or sparse ready, plus one long hold-off
  initial begin
    int stretch_left;
    int mode;
    int hold_cnt;
    stretch_left = 0;
    mode         = 0;
    hold_cnt     = 0;
    hold_done    = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_cnt++;
        if (hold_cnt >= 400) hold_done = 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode         = $urandom_range(0, 2);
          stretch_left = $urandom_range(5, 60);
        end
        stretch_left--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          default: out_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  // Offer one element beat; bursts separated by random gaps
  task automatic send_elem(logic [15:0] re, logic [15:0] im);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_ch.valid     <= 1'b1;
    in_ch.elem_real <= re;
    in_ch.elem_imag <= im;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
    beats_sent++;
  endtask

  // Drain, let a partial row settle, then write the size register
  task automatic write_size(logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (MAX_N_DEF + 8) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int sz;
    int n;
    int count;
    cfg_we          = 1'b0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.elem_real = '0;
    in_ch.elem_imag = '0;
    rst_n           = 1'b0;
    hold_req        = 1'b0;
    beats_sent      = 0;
    settings_used   = 1;
    burst_left      = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset size: one full row of most-negative values, largest imaginary sum
    for (int k = 0; k < 32; k++) send_elem(16'h8000, 16'h8000);
    // Size one, and zero acting as one
    write_size(CFG_W'(1));
    send_elem(16'h7fff, 16'h7fff);
    send_elem(16'h8000, 16'h7fff);
    send_elem(16'h7fff, 16'h8000);
    write_size(CFG_W'(0));
    send_elem(16'h8000, 16'h0000);
    send_elem(16'h0000, 16'hffff);
    // Size two: full matrix, then wrap into the next one
    write_size(CFG_W'(2));
    for (int k = 0; k < 6; k++) send_elem(pick_elem(), pick_elem());

    // Random phases of mostly whole rows, some ending mid-row
    hold_req = 1'b1;
    while (beats_sent < 300) begin
      case ($urandom_range(0, 9))
        0: sz = 0;
        1: sz = 63;
        2: sz = 32;
        default: sz = $urandom_range(1, 8);
      endcase
      write_size(CFG_W'(sz));
      n = (sz == 0) ? 1 : (sz > 32 ? 32 : sz);
      count = (n <= 8) ? $urandom_range(1, 2 * n) * n : $urandom_range(1, 3) * n;
      if (n > 1 && $urandom_range(0, 4) == 0) count += $urandom_range(1, n - 1);
      for (int k = 0; k < count; k++) send_elem(pick_elem(), pick_elem());
    end
    in_ch.valid <= 1'b0;

    // Drain and settle
    while (pending != 0) @(negedge clk);
    repeat (MAX_N_DEF + 8) @(negedge clk);
    $display("Sent %0d element beats over %0d size settings; %0d result beats checked.",
             beats_sent, settings_used, checked);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
